[src/xlsu_pkg.sv]
// Package for the x86 logic and shift unit: opcodes, size and condition codes,
// request, response and flag types. No dependencies.
`timescale 1ns / 1ps

package xlsu_pkg;

  typedef enum logic [3:0] {
    OP_TEST  = 4'd0,
    OP_AND   = 4'd1,
    OP_XOR   = 4'd2,
    OP_OR    = 4'd3,
    OP_SAR   = 4'd4,
    OP_SHL   = 4'd5,
    OP_SHR   = 4'd6,
    OP_SETCC = 4'd7,
    OP_NOT   = 4'd8,
    OP_ROL   = 4'd9,
    OP_SHLD  = 4'd10,
    OP_SHRD  = 4'd11
  } op_t;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;

  // Condition groups (condition number without its negate bit)
  localparam logic [2:0] CC_O  = 3'd0;
  localparam logic [2:0] CC_B  = 3'd1;
  localparam logic [2:0] CC_Z  = 3'd2;
  localparam logic [2:0] CC_BE = 3'd3;
  localparam logic [2:0] CC_S  = 3'd4;
  localparam logic [2:0] CC_P  = 3'd5;
  localparam logic [2:0] CC_L  = 3'd6;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [1:0]  size_code;
    logic [31:0] dest_value;
    logic [31:0] src_value;
    logic [31:0] fill_value;
    logic [3:0]  cond_code;
  } req_t;

  typedef struct packed {
    logic carry;
    logic zero;
    logic sign;
    logic overflow;
  } flags_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        write_dest;
    flags_t      flags;
  } rsp_t;

endpackage

[src/xlsu_req_if.sv]
// Request channel of the logic and shift unit: valid, ready and the
// instruction operands. No dependencies.
`timescale 1ns / 1ps

interface xlsu_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [1:0]  size_code;
  logic [31:0] dest_value;
  logic [31:0] src_value;
  logic [31:0] fill_value;
  logic [3:0]  cond_code;

  modport source (
    output valid, req_type, size_code, dest_value, src_value, fill_value, cond_code,
    input  ready
  );
  modport sink (
    input  valid, req_type, size_code, dest_value, src_value, fill_value, cond_code,
    output ready
  );
endinterface

[src/xlsu_rsp_if.sv]
// Response channel of the logic and shift unit: valid, ready, result and
// flags. No dependencies.
`timescale 1ns / 1ps

interface xlsu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        write_dest;
  logic        carry_out;
  logic        zero_out;
  logic        sign_out;
  logic        overflow_out;

  modport source (
    output valid, result_value, write_dest, carry_out, zero_out, sign_out, overflow_out,
    input  ready
  );
  modport sink (
    input  valid, result_value, write_dest, carry_out, zero_out, sign_out, overflow_out,
    output ready
  );
endinterface

[src/x86_logic_shift_unit.sv]
// Top level of the x86 logic and shift unit: request register, execute step,
// response register and the flag state. Depends on xlsu_pkg, xlsu_req_if,
// xlsu_rsp_if and xlsu_exec.
//
//   channel | interface    | transfer when
//   --------+--------------+------------------------
//   req     | xlsu_req_if  | req.valid && req.ready
//   rsp     | xlsu_rsp_if  | rsp.valid && rsp.ready
//
// One instruction per cycle while the response is not stalled; an instruction
// passes the request register, then the response register.
// Flags update as an instruction moves into the response register, so the
// next instruction sees them at once. Synchronous reset clears valids and flags.
// A stalled response holds both full registers; an empty req_q stays ready.
`timescale 1ns / 1ps

module x86_logic_shift_unit (
  input logic clk,
  input logic rst,
  xlsu_req_if.sink   req,
  xlsu_rsp_if.source rsp
);
  import xlsu_pkg::*;

  req_t   req_q;
  logic   req_vld;
  rsp_t   rsp_q;
  logic   rsp_vld;
  flags_t flags;
  rsp_t   exec_rsp;
  logic   adv;

  xlsu_exec u_exec (
    .req   (req_q),
    .flags (flags),
    .rsp   (exec_rsp)
  );

  assign adv       = req_vld && (!rsp_vld || rsp.ready);
  assign req.ready = !req_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
      rsp_vld <= 1'b0;
      flags   <= '0;
    end else begin
      if (req.ready) begin
        req_vld <= req.valid;
      end
      if (adv) begin
        rsp_vld <= 1'b1;
        flags   <= exec_rsp.flags;
      end else if (rsp.ready) begin
        rsp_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      req_q.req_type   <= req.req_type;
      req_q.size_code  <= req.size_code;
      req_q.dest_value <= req.dest_value;
      req_q.src_value  <= req.src_value;
      req_q.fill_value <= req.fill_value;
      req_q.cond_code  <= req.cond_code;
    end
    if (adv) begin
      rsp_q <= exec_rsp;
    end
  end

  assign rsp.valid        = rsp_vld;
  assign rsp.result_value = rsp_q.result_value;
  assign rsp.write_dest   = rsp_q.write_dest;
  assign rsp.carry_out    = rsp_q.flags.carry;
  assign rsp.zero_out     = rsp_q.flags.zero;
  assign rsp.sign_out     = rsp_q.flags.sign;
  assign rsp.overflow_out = rsp_q.flags.overflow;

endmodule

[src/xlsu_exec.sv]
// Combinational execute step: logic ops, NOT, shifts, rotate, double shifts
// and setcc against the held flags. Depends on xlsu_pkg.
`timescale 1ns / 1ps

module xlsu_exec (
  input  xlsu_pkg::req_t   req,
  input  xlsu_pkg::flags_t flags,
  output xlsu_pkg::rsp_t   rsp
);
  import xlsu_pkg::*;

  logic [31:0] mask;
  logic [31:0] d;
  logic [31:0] f;
  logic [4:0]  c;
  logic [31:0] d_sext;
  logic [31:0] logic_r;
  logic [31:0] shl_r;
  logic [31:0] shr_r;
  logic [31:0] sar_r;
  logic [31:0] rol_r;
  logic [31:0] shld_r;
  logic [31:0] shrd_r;
  logic [31:0] shift_r;
  logic [63:0] rol_v;
  logic [63:0] shld_v;
  logic [63:0] shrd_v;
  logic        cond_r;
  logic        rol_msb;
  logic        shift_msb;
  logic        logic_msb;

  function automatic logic msb_of(input logic [31:0] v, input logic [1:0] sz);
    logic m;
    case (sz)
      SIZE_BYTE: m = v[7];
      SIZE_WORD: m = v[15];
      default:   m = v[31];
    endcase
    return m;
  endfunction

  always_comb begin
    case (req.size_code)
      SIZE_BYTE: mask = 32'h0000_00ff;
      SIZE_WORD: mask = 32'h0000_ffff;
      default:   mask = 32'hffff_ffff;
    endcase
    d = req.dest_value & mask;
    f = req.fill_value & mask;
    c = req.src_value[4:0];

    case (req.size_code)
      SIZE_BYTE: begin
        d_sext = {{24{d[7]}}, d[7:0]};
        rol_v  = {48'b0, d[7:0], d[7:0]} << c[2:0];
        rol_r  = {24'b0, rol_v[15:8]};
        shld_v = {48'b0, d[7:0], f[7:0]} << c;
        shld_r = {24'b0, shld_v[15:8]};
        shrd_v = {48'b0, f[7:0], d[7:0]} >> c;
        shrd_r = {24'b0, shrd_v[7:0]};
      end
      SIZE_WORD: begin
        d_sext = {{16{d[15]}}, d[15:0]};
        rol_v  = {32'b0, d[15:0], d[15:0]} << c[3:0];
        rol_r  = {16'b0, rol_v[31:16]};
        shld_v = {32'b0, d[15:0], f[15:0]} << c;
        shld_r = {16'b0, shld_v[31:16]};
        shrd_v = {32'b0, f[15:0], d[15:0]} >> c;
        shrd_r = {16'b0, shrd_v[15:0]};
      end
      default: begin
        d_sext = d;
        rol_v  = {d, d} << c;
        rol_r  = rol_v[63:32];
        shld_v = {d, f} << c;
        shld_r = shld_v[63:32];
        shrd_v = {f, d} >> c;
        shrd_r = shrd_v[31:0];
      end
    endcase

    shl_r = (d << c) & mask;
    shr_r = d >> c;
    sar_r = $signed(d_sext) >>> c;
    sar_r = sar_r & mask;

    case (req.req_type)
      OP_XOR:  logic_r = (d ^ req.src_value) & mask;
      OP_OR:   logic_r = (d | req.src_value) & mask;
      default: logic_r = d & req.src_value;
    endcase

    case (req.req_type)
      OP_SAR:  shift_r = sar_r;
      OP_SHL:  shift_r = shl_r;
      OP_SHR:  shift_r = shr_r;
      OP_SHLD: shift_r = shld_r;
      default: shift_r = shrd_r;
    endcase

    logic_msb = msb_of(logic_r, req.size_code);
    shift_msb = msb_of(shift_r, req.size_code);
    rol_msb   = msb_of(rol_r, req.size_code);

    case (req.cond_code[3:1])
      CC_O:    cond_r = flags.overflow;
      CC_B:    cond_r = flags.carry;
      CC_Z:    cond_r = flags.zero;
      CC_BE:   cond_r = flags.carry | flags.zero;
      CC_S:    cond_r = flags.sign;
      CC_P:    cond_r = 1'b0;
      CC_L:    cond_r = flags.sign ^ flags.overflow;
      default: cond_r = flags.zero | (flags.sign ^ flags.overflow);
    endcase

    rsp.result_value = d;
    rsp.write_dest   = 1'b0;
    rsp.flags        = flags;

    case (req.req_type)
      OP_TEST, OP_AND, OP_XOR, OP_OR: begin
        rsp.flags.zero     = (logic_r == 32'd0);
        rsp.flags.sign     = logic_msb;
        rsp.flags.carry    = 1'b0;
        rsp.flags.overflow = 1'b0;
        if (req.req_type != OP_TEST) begin
          rsp.result_value = logic_r;
          rsp.write_dest   = 1'b1;
        end
      end
      OP_SAR, OP_SHL, OP_SHR, OP_SHLD, OP_SHRD: begin
        if (c != 5'd0) begin
          rsp.result_value = shift_r;
          rsp.write_dest   = 1'b1;
          rsp.flags.zero   = (shift_r == 32'd0);
          rsp.flags.sign   = shift_msb;
        end
      end
      OP_SETCC: begin
        rsp.result_value = {31'b0, cond_r ^ req.cond_code[0]};
        rsp.write_dest   = 1'b1;
      end
      OP_NOT: begin
        rsp.result_value = ~d & mask;
        rsp.write_dest   = 1'b1;
      end
      OP_ROL: begin
        if (c != 5'd0) begin
          rsp.result_value = rol_r;
          rsp.write_dest   = 1'b1;
          rsp.flags.carry  = rol_r[0];
          if (c == 5'd1) begin
            rsp.flags.overflow = rol_r[0] ^ rol_msb;
          end
        end
      end
      default: begin
        rsp.result_value = d;
      end
    endcase
  end

endmodule

[test/tb_x86_logic_shift_unit.sv]
// Testbench for x86_logic_shift_unit: directed and random instructions on the
// request channel, flag-tracking predictor and in-order result check.
// Depends on xlsu_pkg, xlsu_req_if, xlsu_rsp_if and x86_logic_shift_unit.
`timescale 1ns / 1ps

module tb_x86_logic_shift_unit;
  import xlsu_pkg::*;

  localparam logic [1:0] SIZE_DWORD = 2'd2;
  localparam logic [1:0] SIZE_ALIAS = 2'd3;
  localparam logic [3:0] OP_UNUSED_LO = 4'd12;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;
  localparam int RANDOM_ITEMS = 1425;
  localparam int HOLD_AT_A = 300;
  localparam int HOLD_AT_B = 1000;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  class alu_result_scoreboard;
    rsp_t   expected_results[$];
    flags_t held = '0;
    int     failures;

    function void set_zs(logic [31:0] v, int unsigned w, logic [31:0] mask);
      held.zero = (v & mask) == 32'h0;
      held.sign = v[w-1];
    endfunction

    function logic cond_holds(logic [3:0] cc);
      logic r;
      case (cc[3:1])
        CC_O:    r = held.overflow;
        CC_B:    r = held.carry;
        CC_Z:    r = held.zero;
        CC_BE:   r = held.carry | held.zero;
        CC_S:    r = held.sign;
        CC_P:    r = 1'b0;
        CC_L:    r = held.sign ^ held.overflow;
        default: r = held.zero | (held.sign ^ held.overflow);
      endcase
      return cc[0] ? ~r : r;
    endfunction

    function rsp_t compute_result(req_t r);
      int unsigned w;
      int unsigned k;
      logic [31:0] mask;
      logic [31:0] d;
      logic [31:0] s;
      logic [31:0] f;
      logic [31:0] x;
      logic [31:0] res;
      logic [4:0]  cnt;
      logic [63:0] v;
      logic        wr;
      rsp_t        out;
      case (r.size_code)
        SIZE_BYTE: w = 8;
        SIZE_WORD: w = 16;
        default:   w = 32;
      endcase
      mask = (w == 32) ? 32'hFFFF_FFFF : ((32'h1 << w) - 32'h1);
      d = r.dest_value & mask;
      s = r.src_value;
      f = r.fill_value & mask;
      cnt = s[4:0];
      res = d;
      wr = 1'b0;
      case (r.req_type)
        OP_TEST, OP_AND, OP_XOR, OP_OR: begin
          if (r.req_type == OP_XOR) res = (d ^ s) & mask;
          else if (r.req_type == OP_OR) res = (d | s) & mask;
          else res = d & s & mask;
          set_zs(res, w, mask);
          held.carry = 1'b0;
          held.overflow = 1'b0;
          if (r.req_type == OP_TEST) res = d;
          else wr = 1'b1;
        end
        OP_SAR, OP_SHL, OP_SHR: begin
          if (cnt != 5'd0) begin
            if (r.req_type == OP_SHL) begin
              res = (d << cnt) & mask;
            end else if (r.req_type == OP_SHR) begin
              res = d >> cnt;
            end else begin
              x = d[w-1] ? (d | ~mask) : d;
              res = $signed(x) >>> cnt;
              res = res & mask;
            end
            set_zs(res, w, mask);
            wr = 1'b1;
          end
        end
        OP_SETCC: begin
          res = cond_holds(r.cond_code) ? 32'd1 : 32'd0;
          wr = 1'b1;
        end
        OP_NOT: begin
          res = ~d & mask;
          wr = 1'b1;
        end
        OP_ROL: begin
          if (cnt != 5'd0) begin
            k = cnt % w;
            if (k != 0) res = ((d << k) | (d >> (w - k))) & mask;
            held.carry = res[0];
            if (cnt == 5'd1) held.overflow = res[0] ^ res[w-1];
            wr = 1'b1;
          end
        end
        OP_SHLD, OP_SHRD: begin
          if (cnt != 5'd0) begin
            if (r.req_type == OP_SHLD) begin
              v = (64'(d) << w) | 64'(f);
              res = 32'(((v << cnt) >> w)) & mask;
            end else begin
              v = (64'(f) << w) | 64'(d);
              res = 32'(v >> cnt) & mask;
            end
            set_zs(res, w, mask);
            wr = 1'b1;
          end
        end
        default: ;
      endcase
      out.result_value = res;
      out.write_dest = wr;
      out.flags = held;
      return out;
    endfunction

    function void note_request(req_t r);
      expected_results.push_back(compute_result(r));
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result: value %h write %b flags %b",
                   got.result_value, got.write_dest, got.flags);
        return;
      end
      exp = expected_results.pop_front();
      if (got.result_value !== exp.result_value || got.write_dest !== exp.write_dest ||
          got.flags.carry !== exp.flags.carry || got.flags.zero !== exp.flags.zero ||
          got.flags.sign !== exp.flags.sign || got.flags.overflow !== exp.flags.overflow) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("mismatch: value %h/%h write %b/%b cf %b/%b zf %b/%b sf %b/%b of %b/%b",
                   exp.result_value, got.result_value, exp.write_dest, got.write_dest,
                   exp.flags.carry, got.flags.carry, exp.flags.zero, got.flags.zero,
                   exp.flags.sign, got.flags.sign, exp.flags.overflow, got.flags.overflow);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  xlsu_req_if req_ch ();
  xlsu_rsp_if rsp_ch ();

  x86_logic_shift_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  alu_result_scoreboard results = new();
  int sent_count = 0;
  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;
  int idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic req_t make_req(logic [3:0] op, logic [1:0] size, logic [31:0] d,
                                    logic [31:0] s, logic [31:0] f, logic [3:0] cc);
    req_t r;
    r.req_type = op;
    r.size_code = size;
    r.dest_value = d;
    r.src_value = s;
    r.fill_value = f;
    r.cond_code = cc;
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic int draw_gap();
    if (sent_count >= HOLD_AT_A - 10 && sent_count < HOLD_AT_A + 40) return 0;
    if (sent_count >= HOLD_AT_B - 10 && sent_count < HOLD_AT_B + 40) return 0;
    return tx_no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic send_instruction(input req_t r);
    int gap;
    if (sent_count % 50 == 0) tx_no_idle = ($urandom_range(0, 3) == 0);
    gap = draw_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.req_type;
    req_ch.size_code <= r.size_code;
    req_ch.dest_value <= r.dest_value;
    req_ch.src_value <= r.src_value;
    req_ch.fill_value <= r.fill_value;
    req_ch.cond_code <= r.cond_code;
    do @(posedge clk); while (!req_ch.ready);
    sent_count++;
  endtask

  task automatic run_directed();
    send_instruction(make_req(OP_OR, SIZE_BYTE, 32'h0, 32'h0, 32'h0, 4'h0));
    send_instruction(make_req(OP_AND, SIZE_DWORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'h0));
    send_instruction(make_req(OP_XOR, SIZE_WORD, 32'hFFFF_1234, 32'h0000_9234, 32'h0, 4'h0));
    send_instruction(make_req(OP_TEST, SIZE_DWORD, 32'h8000_0001, 32'h8000_0000, 32'h0, 4'h0));
    send_instruction(make_req(OP_NOT, SIZE_BYTE, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0));
    send_instruction(make_req(OP_SHL, SIZE_DWORD, 32'h1234_5678, 32'hFFFF_FFE0, 32'h0, 4'h0));
    send_instruction(make_req(OP_SHL, SIZE_BYTE, 32'hFF, 32'd31, 32'h0, 4'h0));
    send_instruction(make_req(OP_SHR, SIZE_WORD, 32'hFFFF, 32'd16, 32'h0, 4'h0));
    send_instruction(make_req(OP_SAR, SIZE_BYTE, 32'h80, 32'd20, 32'h0, 4'h0));
    send_instruction(make_req(OP_SAR, SIZE_DWORD, 32'h8000_0000, 32'd31, 32'h0, 4'h0));
    send_instruction(make_req(OP_ROL, SIZE_BYTE, 32'h40, 32'd1, 32'h0, 4'h0));
    send_instruction(make_req(OP_ROL, SIZE_BYTE, 32'h81, 32'd8, 32'h0, 4'h0));
    send_instruction(make_req(OP_ROL, SIZE_WORD, 32'h8001, 32'd17, 32'h0, 4'h0));
    send_instruction(make_req(OP_ROL, SIZE_DWORD, 32'hDEAD_BEEF, 32'h0, 32'h0, 4'h0));
    send_instruction(make_req(OP_SHLD, SIZE_BYTE, 32'hA5, 32'd12, 32'h3C, 4'h0));
    send_instruction(make_req(OP_SHRD, SIZE_WORD, 32'h1234, 32'd20, 32'hF00F, 4'h0));
    send_instruction(make_req(OP_SHLD, SIZE_DWORD, 32'h8000_0001, 32'd31, 32'hFFFF_0000,
                              4'h0));
    send_instruction(make_req(OP_SHRD, SIZE_DWORD, 32'h1, 32'h20, 32'h5555_5555, 4'h0));
    send_instruction(make_req(OP_AND, SIZE_ALIAS, 32'hF0F0_F0F0, 32'hFFFF_0000, 32'h0, 4'h0));
    send_instruction(make_req(OP_UNUSED_LO, SIZE_BYTE, 32'h55, 32'h1, 32'h0, 4'h0));
    send_instruction(make_req(OP_UNUSED_HI, SIZE_DWORD, 32'hFFFF_FFFF, 32'h3, 32'h0, 4'hF));
    send_instruction(make_req(OP_SETCC, SIZE_BYTE, 32'hFF, 32'h0, 32'h0, {CC_P, 1'b0}));
    send_instruction(make_req(OP_SETCC, SIZE_BYTE, 32'hFF, 32'h0, 32'h0, {CC_P, 1'b1}));
    send_instruction(make_req(OP_SETCC, SIZE_WORD, 32'h0, 32'h0, 32'h0, {CC_B, 1'b0}));
    send_instruction(make_req(OP_SETCC, SIZE_DWORD, 32'h0, 32'h0, 32'h0, 4'hF));
  endtask

  task automatic run_random();
    int valid_ops;
    logic [3:0] op;
    valid_ops = 0;
    while (valid_ops < RANDOM_ITEMS) begin
      if ($urandom_range(0, 31) == 0) begin
        op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else begin
        op = 4'($urandom_range(0, OP_SHRD));
        valid_ops++;
      end
      send_instruction(make_req(op, 2'($urandom_range(0, 3)), pick_word(), pick_word(),
                                pick_word(), 4'($urandom_range(0, 15))));
    end
  endtask

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.req_type <= OP_TEST;
    req_ch.size_code <= SIZE_BYTE;
    req_ch.dest_value <= 32'h0;
    req_ch.src_value <= 32'h0;
    req_ch.fill_value <= 32'h0;
    req_ch.cond_code <= 4'h0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    int wait_cycles;
    int taken;
    taken = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 50 == 0) rx_no_idle = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AT_A || taken == HOLD_AT_B) wait_cycles = HOLD_CYCLES;
      else wait_cycles = rx_no_idle ? 0 : $urandom_range(0, 19);
      if (wait_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    rsp_t got;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.result_value = rsp_ch.result_value;
        got.write_dest = rsp_ch.write_dest;
        got.flags.carry = rsp_ch.carry_out;
        got.flags.zero = rsp_ch.zero_out;
        got.flags.sign = rsp_ch.sign_out;
        got.flags.overflow = rsp_ch.overflow_out;
        results.check_response(got);
      end
      if (req_ch.valid && req_ch.ready)
        results.note_request(make_req(req_ch.req_type, req_ch.size_code, req_ch.dest_value,
                                      req_ch.src_value, req_ch.fill_value,
                                      req_ch.cond_code));
      if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

[sim.f]
src/xlsu_pkg.sv
src/xlsu_req_if.sv
src/xlsu_rsp_if.sv
src/xlsu_exec.sv
src/x86_logic_shift_unit.sv
test/tb_x86_logic_shift_unit.sv
